// ===== rtl/u8esc_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 sanitizer.
`default_nettype none

package u8esc_pkg;

  // Input transaction: one raw byte of the string
  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_t;

  // Output transaction: one byte of sanitized text
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;
  } out_t;

  // Work passed from the classifier to the expander: up to four source bytes,
  // each sent raw or as a hex escape, in slot order
  typedef struct packed {
    logic [3:0][7:0] src;
    logic [3:0]      esc;
    logic [2:0]      num;
    logic            last;
  } cmd_t;

  // Command queue geometry
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Byte values used by the classifier
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContTag    = 8'h80;
  localparam logic [7:0] Lead2Lo    = 8'hC2;
  localparam logic [7:0] Lead2Hi    = 8'hDF;
  localparam logic [7:0] Lead3Lo    = 8'hE0;
  localparam logic [7:0] Lead3Hi    = 8'hEF;
  localparam logic [7:0] Lead4Lo    = 8'hF0;
  localparam logic [7:0] Lead4Hi    = 8'hF4;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] SecondA0   = 8'hA0;
  localparam logic [7:0] Second90   = 8'h90;

  // Escape characters
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChDigit0    = 8'h30;
  localparam logic [7:0] ChLetterOff = 8'h37;

  // Character positions within one escape
  localparam logic [1:0] ChrSlash = 2'd0;
  localparam logic [1:0] ChrX     = 2'd1;
  localparam logic [1:0] ChrHi    = 2'd2;
  localparam logic [1:0] ChrLo    = 2'd3;

  // Sequence length for a lead byte, zero when it cannot lead
  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] len;
    begin
      len = 3'd0;
      if (lead < ContTag) len = 3'd1;
      else if (lead >= Lead2Lo && lead <= Lead2Hi) len = 3'd2;
      else if (lead >= Lead3Lo && lead <= Lead3Hi) len = 3'd3;
      else if (lead >= Lead4Lo && lead <= Lead4Hi) len = 3'd4;
      return len;
    end
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContTag;
  endfunction

  // Range check on the second byte of a sequence
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    begin
      ok = 1'b1;
      if (lead == LeadE0 && b < SecondA0) ok = 1'b0;
      if (lead == LeadED && b >= SecondA0) ok = 1'b0;
      if (lead == LeadF0 && b < Second90) ok = 1'b0;
      if (lead == LeadF4 && b >= Second90) ok = 1'b0;
      return ok;
    end
  endfunction

  // Upper-case hex character for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    begin
      if (nib < 4'd10) c = ChDigit0 + {4'h0, nib};
      else c = ChLetterOff + {4'h0, nib};
      return c;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/u8esc_front.sv =====
// Classifier: holds partial sequences and turns each byte into expander work.
`default_nettype none

module u8esc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           byte_valid,
  output logic                byte_stall,
  input  wire u8esc_pkg::in_t byte_data,
  input  wire logic           queue_full,
  output logic                push,
  output u8esc_pkg::cmd_t     push_data
);

  logic [7:0] pending_lead;
  logic [7:0] pending_cont [2];
  logic [1:0] pending_count;
  logic       pending_valid;

  logic [7:0] pending_lead_next;
  logic [7:0] cont0_next;
  logic [7:0] cont1_next;
  logic [1:0] pending_count_next;
  logic       pending_valid_next;
  logic       cont_we;
  logic       accept;

  // Stall only on a full queue
  assign byte_stall = queue_full;
  assign accept     = byte_valid && !byte_stall;

  // Classify the byte against the held sequence
  always_comb begin
    logic [7:0] b;
    logic [2:0] n;
    logic [2:0] need;
    logic       ok;
    logic       scan;
    logic [2:0] blen;
    b    = byte_data.in_byte;
    n    = 3'd0;
    scan = 1'b0;
    need = u8esc_pkg::seq_len(pending_lead);
    ok   = u8esc_pkg::is_cont(b) &&
           (pending_count != 2'd0 || u8esc_pkg::second_ok(pending_lead, b));
    blen = u8esc_pkg::seq_len(b);
    push_data          = '0;
    pending_lead_next  = pending_lead;
    cont0_next         = pending_cont[0];
    cont1_next         = pending_cont[1];
    pending_count_next = pending_count;
    pending_valid_next = pending_valid;
    cont_we            = 1'b0;

    if (pending_valid) begin
      if (ok && need >= 3'd2) begin
        if ({1'b0, pending_count} + 3'd2 >= need) begin
          // Complete: pass the whole sequence through
          push_data.src[n[1:0]] = pending_lead;
          push_data.esc[n[1:0]] = 1'b0;
          n = n + 3'd1;
          for (int i = 0; i < 2; i++) begin
            if (i < int'(pending_count)) begin
              push_data.src[n[1:0]] = pending_cont[i];
              push_data.esc[n[1:0]] = 1'b0;
              n = n + 3'd1;
            end
          end
          push_data.src[n[1:0]] = b;
          push_data.esc[n[1:0]] = 1'b0;
          n = n + 3'd1;
          pending_valid_next = 1'b0;
          pending_count_next = 2'd0;
          pending_lead_next  = 8'h00;
        end else begin
          // Hold the continuation byte
          cont_we = 1'b1;
          if (pending_count[0]) cont1_next = b;
          else cont0_next = b;
          pending_count_next = pending_count + 2'd1;
        end
      end else begin
        // Fail: escape the held bytes, then rescan this one
        push_data.src[n[1:0]] = pending_lead;
        push_data.esc[n[1:0]] = 1'b1;
        n = n + 3'd1;
        for (int i = 0; i < 2; i++) begin
          if (i < int'(pending_count)) begin
            push_data.src[n[1:0]] = pending_cont[i];
            push_data.esc[n[1:0]] = 1'b1;
            n = n + 3'd1;
          end
        end
        pending_valid_next = 1'b0;
        pending_count_next = 2'd0;
        pending_lead_next  = 8'h00;
        scan = 1'b1;
      end
    end else begin
      scan = 1'b1;
    end

    // Scan the byte as a fresh start
    if (scan) begin
      if (blen == 3'd1) begin
        push_data.src[n[1:0]] = b;
        push_data.esc[n[1:0]] = 1'b0;
        n = n + 3'd1;
      end else if (blen == 3'd0) begin
        push_data.src[n[1:0]] = b;
        push_data.esc[n[1:0]] = 1'b1;
        n = n + 3'd1;
      end else begin
        pending_lead_next  = b;
        pending_count_next = 2'd0;
        pending_valid_next = 1'b1;
      end
    end

    // Flush whatever is still held at the end of the string
    if (byte_data.string_end && pending_valid_next) begin
      push_data.src[n[1:0]] = pending_lead_next;
      push_data.esc[n[1:0]] = 1'b1;
      n = n + 3'd1;
      if (pending_count_next != 2'd0) begin
        push_data.src[n[1:0]] = cont0_next;
        push_data.esc[n[1:0]] = 1'b1;
        n = n + 3'd1;
      end
      if (pending_count_next == 2'd2) begin
        push_data.src[n[1:0]] = cont1_next;
        push_data.esc[n[1:0]] = 1'b1;
        n = n + 3'd1;
      end
      pending_valid_next = 1'b0;
      pending_count_next = 2'd0;
      pending_lead_next  = 8'h00;
    end

    push_data.num  = n;
    push_data.last = byte_data.string_end;
    push           = accept && (n != 3'd0);
  end

  // Advance the held-sequence control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead  <= 8'h00;
      pending_count <= 2'd0;
      pending_valid <= 1'b0;
    end else if (accept) begin
      pending_lead  <= pending_lead_next;
      pending_count <= pending_count_next;
      pending_valid <= pending_valid_next;
    end
  end

  // Hold continuation bytes
  always_ff @(posedge clk) begin
    if (accept && cont_we) begin
      pending_cont[0] <= cont0_next;
      pending_cont[1] <= cont1_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u8esc_fifo.sv =====
// Short command queue between the classifier and the expander.
`default_nettype none

module u8esc_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire u8esc_pkg::cmd_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output u8esc_pkg::cmd_t      head
);

  u8esc_pkg::cmd_t entries [u8esc_pkg::QueueDepth];

  logic [u8esc_pkg::QueuePtrW-1:0] wr_ptr;
  logic [u8esc_pkg::QueuePtrW-1:0] rd_ptr;
  logic [u8esc_pkg::QueueCntW-1:0] count;

  assign full  = (count == u8esc_pkg::QueueCntW'(u8esc_pkg::QueueDepth));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== rtl/u8esc_back.sv =====
// Expander: walks each command and emits raw bytes or hex escapes.
`default_nettype none

module u8esc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            empty,
  input  wire u8esc_pkg::cmd_t head,
  output logic                 pop,
  output logic                 text_valid,
  input  wire logic            text_stall,
  output u8esc_pkg::out_t      text_data
);

  logic [1:0] src_idx;
  logic [1:0] chr;

  logic [7:0]      cur;
  logic            cur_esc;
  logic            char_done;
  logic            last_src;
  logic            advance;
  logic [7:0]      ch;

  // Select the next character from the head command
  always_comb begin
    cur       = head.src[src_idx];
    cur_esc   = head.esc[src_idx];
    char_done = !cur_esc || (chr == u8esc_pkg::ChrLo);
    last_src  = ({1'b0, src_idx} + 3'd1) == head.num;
    advance   = !empty && (!text_valid || !text_stall);
    pop       = advance && char_done && last_src;
    if (!cur_esc) begin
      ch = cur;
    end else begin
      case (chr)
        u8esc_pkg::ChrSlash: ch = u8esc_pkg::ChBackslash;
        u8esc_pkg::ChrX:     ch = u8esc_pkg::ChLowerX;
        u8esc_pkg::ChrHi:    ch = u8esc_pkg::hex_char(cur[7:4]);
        default:             ch = u8esc_pkg::hex_char(cur[3:0]);
      endcase
    end
  end

  // Step through characters and source bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_idx    <= 2'd0;
      chr        <= u8esc_pkg::ChrSlash;
      text_valid <= 1'b0;
    end else begin
      if (advance) begin
        text_valid <= 1'b1;
        if (char_done) begin
          chr     <= u8esc_pkg::ChrSlash;
          src_idx <= last_src ? 2'd0 : src_idx + 2'd1;
        end else begin
          chr <= chr + 2'd1;
        end
      end else if (!text_stall) begin
        text_valid <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      text_data.out_byte  <= ch;
      text_data.run_last  <= char_done && last_src;
      text_data.text_last <= char_done && last_src && head.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf8_sanitizer_escape.sv =====
// Top level of the strict UTF-8 sanitizer with hex escapes.
//
//   channel | direction | handshake                 | payload
//   byte    | in        | byte_valid / byte_stall   | in_byte, string_end
//   text    | out       | text_valid / text_stall   | out_byte, run_last, text_last
//
// Valid text flows at one byte per cycle while text_stall is low; each escaped byte
// leaves the expander as four characters, so throughput is set by the expander's
// output port. The classifier keeps taking bytes until the four-entry command
// queue fills. Work for an accepted byte passes through the command queue, then the
// expander's output register. Reset is synchronous and clears held-sequence state,
// the queue pointers and the output valid flag; no clearing pass is needed.
`default_nettype none

module utf8_sanitizer_escape (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           byte_valid,
  output logic                byte_stall,
  input  wire u8esc_pkg::in_t byte_data,
  output logic                text_valid,
  input  wire logic           text_stall,
  output u8esc_pkg::out_t     text_data
);

  logic            push;
  u8esc_pkg::cmd_t push_data;
  logic            queue_full;
  logic            pop;
  logic            queue_empty;
  u8esc_pkg::cmd_t head;

  u8esc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  u8esc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  u8esc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (queue_empty),
    .head       (head),
    .pop        (pop),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_data  (text_data)
  );

endmodule

`default_nettype wire

// ===== tb/utf8_escape_check.sv =====
// Checker for the UTF-8 sanitizer: predicts the text stream and compares it.
`timescale 1ns / 1ps

module utf8_escape_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  input  logic            byte_stall,
  input  u8esc_pkg::in_t  byte_data,
  input  logic            text_valid,
  input  logic            text_stall,
  input  u8esc_pkg::out_t text_data,
  output int              fail_count,
  output int              text_due
);

  localparam logic [7:0] TrailMask   = 8'hC0;
  localparam logic [7:0] TrailTag    = 8'h80;
  localparam logic [7:0] TwoLo       = 8'hC2;
  localparam logic [7:0] TwoHi       = 8'hDF;
  localparam logic [7:0] ThreeLo     = 8'hE0;
  localparam logic [7:0] ThreeHi     = 8'hEF;
  localparam logic [7:0] FourLo      = 8'hF0;
  localparam logic [7:0] FourHi      = 8'hF4;
  localparam logic [7:0] LeadE0      = 8'hE0;
  localparam logic [7:0] LeadED      = 8'hED;
  localparam logic [7:0] LeadF0      = 8'hF0;
  localparam logic [7:0] LeadF4      = 8'hF4;
  localparam logic [7:0] BoundA0     = 8'hA0;
  localparam logic [7:0] Bound90     = 8'h90;
  localparam logic [7:0] BackslashCh = 8'h5C;
  localparam logic [7:0] LowerXCh    = 8'h78;
  localparam logic [7:0] DigitZero   = 8'h30;
  localparam logic [7:0] LetterA     = 8'h41;
  localparam int         MaxRun      = 16;
  localparam int         MaxPrinted  = 100;

  // Held partial sequence
  logic [7:0] held_lead;
  logic [7:0] held_tail [2];
  int         held_tails;
  bit         seq_open;

  u8esc_pkg::out_t run_q [$];
  u8esc_pkg::out_t text_due_q [$];
  int              mismatches = 0;

  assign fail_count = mismatches;

  function automatic int lead_length(input logic [7:0] b);
    if (b < TrailTag) return 1;
    if (b >= TwoLo && b <= TwoHi) return 2;
    if (b >= ThreeLo && b <= ThreeHi) return 3;
    if (b >= FourLo && b <= FourHi) return 4;
    return 0;
  endfunction

  function automatic bit is_trail(input logic [7:0] b);
    return (b & TrailMask) == TrailTag;
  endfunction

  // Restrict the second byte after the leads that have narrow ranges
  function automatic bit second_in_range(input logic [7:0] lead, input logic [7:0] b);
    if (lead == LeadE0 && b < BoundA0) return 1'b0;
    if (lead == LeadED && b >= BoundA0) return 1'b0;
    if (lead == LeadF0 && b < Bound90) return 1'b0;
    if (lead == LeadF4 && b >= Bound90) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return DigitZero + {4'h0, n};
    return LetterA + {4'h0, n} - 8'd10;
  endfunction

  task automatic put_text(input logic [7:0] ch);
    u8esc_pkg::out_t t;
    t.out_byte  = ch;
    t.run_last  = 1'b0;
    t.text_last = 1'b0;
    if (run_q.size() < MaxRun) run_q = {run_q, t};
  endtask

  task automatic put_escape(input logic [7:0] b);
    put_text(BackslashCh);
    put_text(LowerXCh);
    put_text(hex_digit(b[7:4]));
    put_text(hex_digit(b[3:0]));
  endtask

  task automatic close_seq();
    seq_open   = 1'b0;
    held_tails = 0;
    held_lead  = 8'h00;
  endtask

  // Escape the lead and every held trail byte, in order
  task automatic escape_held();
    int i;
    put_escape(held_lead);
    for (i = 0; i < held_tails; i++) put_escape(held_tail[i]);
    close_seq();
  endtask

  task automatic start_fresh(input logic [7:0] b);
    int len;
    len = lead_length(b);
    if (len == 1) begin
      put_text(b);
    end else if (len == 0) begin
      put_escape(b);
    end else begin
      held_lead  = b;
      held_tails = 0;
      seq_open   = 1'b1;
    end
  endtask

  // Work out the text bytes that one input transaction produces
  task automatic sanitize_byte(input u8esc_pkg::in_t item);
    int need;
    int got;
    int i;
    bit fits;
    run_q.delete();
    if (seq_open) begin
      need = lead_length(held_lead);
      got  = held_tails;
      fits = is_trail(item.in_byte) &&
             (got != 0 || second_in_range(held_lead, item.in_byte));
      if (fits && need >= 2) begin
        if (got + 2 >= need) begin
          put_text(held_lead);
          for (i = 0; i < got; i++) put_text(held_tail[i]);
          put_text(item.in_byte);
          close_seq();
        end else begin
          held_tail[got] = item.in_byte;
          held_tails     = got + 1;
        end
      end else begin
        escape_held();
        start_fresh(item.in_byte);
      end
    end else begin
      start_fresh(item.in_byte);
    end
    // Flush a sequence cut short by the end of the string
    if (item.string_end && seq_open) escape_held();
    if (run_q.size() > 0) begin
      run_q[run_q.size() - 1].run_last  = 1'b1;
      run_q[run_q.size() - 1].text_last = item.string_end;
    end
    text_due_q = {text_due_q, run_q};
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxPrinted) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Predict on each accepted byte, compare on each accepted text byte
  always @(posedge clk) begin
    u8esc_pkg::out_t want;
    if (rst) begin
      close_seq();
      held_tail[0] = 8'h00;
      held_tail[1] = 8'h00;
      text_due_q.delete();
    end else begin
      if (byte_valid && !byte_stall) sanitize_byte(byte_data);
      if (text_valid && !text_stall) begin
        if (text_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected text byte %02h", text_data.out_byte));
        end else begin
          want = text_due_q.pop_front();
          if (text_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      text_data.out_byte, want.out_byte));
          if (text_data.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                      text_data.run_last, want.run_last, want.out_byte));
          if (text_data.text_last !== want.text_last)
            report_mismatch($sformatf("text_last %b, expected %b on byte %02h",
                                      text_data.text_last, want.text_last, want.out_byte));
        end
      end
    end
    text_due <= text_due_q.size();
  end

endmodule

// ===== tb/tb_utf8_sanitizer_escape.sv =====
// Top of the UTF-8 sanitizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_utf8_sanitizer_escape;

  localparam int HoldOffCycles = 60;
  localparam int RandomBytes   = 95;

  logic            clk = 1'b0;
  logic            rst;
  logic            byte_valid;
  logic            byte_stall;
  u8esc_pkg::in_t  byte_data;
  logic            text_valid;
  logic            text_stall;
  u8esc_pkg::out_t text_data;
  int              fail_count;
  int              text_due;

  int byte_idle_pct  = 33;
  int text_stall_pct = 33;
  int hold_off_asks  = 0;
  int hold_off_done  = 0;
  int random_sent    = 0;

  logic [7:0] string_bytes [$];

  utf8_sanitizer_escape i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_data  (text_data)
  );

  utf8_escape_check i_check (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_data  (text_data),
    .fail_count (fail_count),
    .text_due   (text_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the text side at random; serve each hold-off request in full
  initial begin
    int held;
    text_stall <= 1'b0;
    forever begin
      if (hold_off_done != hold_off_asks) begin
        hold_off_done++;
        text_stall <= 1'b1;
        for (held = 0; held < HoldOffCycles; held++) @(posedge clk);
      end else begin
        text_stall <= ($urandom_range(99) < text_stall_pct);
        @(posedge clk);
      end
    end
  end

  // Offer one byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < byte_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= '{in_byte: b, string_end: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic send_string();
    int i;
    for (i = 0; i < string_bytes.size(); i++)
      send_byte(string_bytes[i], i == string_bytes.size() - 1);
  endtask

  function automatic logic [7:0] trail_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Append one character: mostly well formed, otherwise cut short or corrupted
  task automatic add_char(input bit well_formed);
    logic [7:0] unit [$];
    logic [7:0] lead;
    int kind;
    kind = $urandom_range(3);
    if (!well_formed && $urandom_range(2) == 0) begin
      string_bytes = {string_bytes, 8'($urandom_range(0, 255))};
      return;
    end
    case (kind)
      0: begin
        unit = {unit, 8'($urandom_range(0, 8'h7F))};
      end
      1: begin
        unit = {unit, 8'($urandom_range(8'hC2, 8'hDF))};
        unit = {unit, trail_byte()};
      end
      2: begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        unit = {unit, lead};
        if (lead == 8'hE0) unit = {unit, 8'($urandom_range(8'hA0, 8'hBF))};
        else if (lead == 8'hED) unit = {unit, 8'($urandom_range(8'h80, 8'h9F))};
        else unit = {unit, trail_byte()};
        unit = {unit, trail_byte()};
      end
      default: begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        unit = {unit, lead};
        if (lead == 8'hF0) unit = {unit, 8'($urandom_range(8'h90, 8'hBF))};
        else if (lead == 8'hF4) unit = {unit, 8'($urandom_range(8'h80, 8'h8F))};
        else unit = {unit, trail_byte()};
        unit = {unit, trail_byte()};
        unit = {unit, trail_byte()};
      end
    endcase
    // Break a multi-byte character: drop its tail or overwrite one trail byte
    if (!well_formed && unit.size() > 1) begin
      if ($urandom_range(1) == 0) void'(unit.pop_back());
      else unit[$urandom_range(1, unit.size() - 1)] = 8'($urandom_range(0, 255));
    end
    string_bytes = {string_bytes, unit};
  endtask

  initial begin
    int chars;
    int c;
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every sequence length, and valid edge ranges
    string_bytes = '{8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'hBF,
                     8'hF0, 8'h90, 8'h80, 8'h80, 8'h7F};
    send_string();
    // Bad second bytes, lone trail byte, non-lead bytes
    string_bytes = '{8'hE0, 8'h80, 8'hED, 8'hA0, 8'hF4, 8'h90,
                     8'hF0, 8'h8F, 8'hC1, 8'hF5};
    send_string();
    // Failed two-trail hold that ends the string with a bad byte
    string_bytes = '{8'hF1, 8'h80, 8'h80, 8'hC0};
    send_string();
    // String ends in the middle of a sequence
    string_bytes = '{8'hE1, 8'hFF};
    string_bytes[1] = 8'h80;
    send_string();

    // Random strings: idling, then a stretch without, then a hold-off
    while (random_sent < RandomBytes) begin
      if (random_sent >= 25 && random_sent < 55) begin
        byte_idle_pct  = 0;
        text_stall_pct = 0;
      end else begin
        byte_idle_pct  = 33;
        text_stall_pct = 33;
      end
      if (random_sent >= 55 && hold_off_asks == 0) hold_off_asks++;
      string_bytes.delete();
      chars = $urandom_range(1, 8);
      for (c = 0; c < chars; c++) add_char($urandom_range(99) < 70);
      send_string();
      random_sent += string_bytes.size();
    end
    byte_valid <= 1'b0;

    // Drain, then allow for the pipeline latency
    @(posedge clk);
    while (text_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
